>>> design/mbps_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mbps_pkg;

   // pattern storage is fixed by the register map: two 64-bit words of bytes
   localparam int PATTERN_SLOTS = 16;
   localparam int BYTE_BITS     = 8;
   localparam int LEN_BITS      = 5;
   localparam int CSR_DATA_BITS = 64;
   localparam int CARE_BITS     = 16;
   localparam int RESULT_BITS   = 32;

   // register indexes on the csr channel
   typedef enum logic [1:0] {
      CSR_PATTERN_LOW  = 2'd0,
      CSR_PATTERN_HIGH = 2'd1,
      CSR_CARE_MASK    = 2'd2,
      CSR_PATTERN_LEN  = 2'd3
   } csr_index_type;

   // per-cell compare setup, derived from the pattern registers
   typedef struct packed {
      logic                 active;
      logic                 care;
      logic [BYTE_BITS-1:0] want_byte;
   } cell_ctrl_type;

endpackage

`default_nettype wire

>>> design/mbps_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module mbps_cell
   import mbps_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 shift_en,
   input  wire logic [BYTE_BITS-1:0] byte_in,
   input  wire cell_ctrl_type        ctrl,
   output logic      [BYTE_BITS-1:0] byte_out,
   output logic                      miss
);

   logic [BYTE_BITS-1:0] byte_ff;

   // window byte, moves one place down the chain per accepted word
   always_ff @(posedge clock) begin
      if (shift_en) begin
         byte_ff <= byte_in;
      end
   end

   assign byte_out = byte_ff;

   // compare the byte this cell is about to hold against its pattern byte
   assign miss = ctrl.active & ctrl.care & (byte_in != ctrl.want_byte);

endmodule

`default_nettype wire

>>> design/masked_byte_pattern_search_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// The result word is registered and appears in the cycle after the byte that
// completes the match (or the region's last byte) is accepted.
// Throughput: one byte per cycle; the window is a chain of byte cells, each comparing
// in parallel; a new byte is taken in the cycle a waiting result leaves, a stalled result
// holds the input. Reset (synchronous, active high) clears the count, the match flag,
// the output valid and the registers (pattern length to 1, all others to 0).

module masked_byte_pattern_search_unit
   import mbps_pkg::*;
#(
   parameter int MAX_PATTERN_BYTES = 16,
   parameter int OFFSET_BITS       = 32
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   // input stream
   input  wire logic                     req_tvalid,
   output logic                          req_tready,
   input  wire logic [BYTE_BITS-1:0]     req_tdata,   // [7:0] data_byte
   input  wire logic                     req_tlast,   // region_end
   // result stream
   output logic                          rsp_tvalid,
   input  wire logic                     rsp_tready,
   output logic      [RESULT_BITS-1:0]   rsp_tdata,   // [31:0] match_offset
   output logic                          rsp_tuser,   // [0] found
   // register writes
   input  wire logic                     csr_valid,
   output logic                          csr_ready,
   input  wire logic [1:0]               csr_index,
   input  wire logic [CSR_DATA_BITS-1:0] csr_data
);

   localparam int CAP = (MAX_PATTERN_BYTES < PATTERN_SLOTS) ? MAX_PATTERN_BYTES
                                                            : PATTERN_SLOTS;
   localparam logic [LEN_BITS-1:0]    CAP_LEN   = LEN_BITS'(CAP);
   localparam logic [OFFSET_BITS-1:0] COUNT_MAX = '1;

   // configuration registers
   logic [CSR_DATA_BITS-1:0] pattern_low_ff;
   logic [CSR_DATA_BITS-1:0] pattern_high_ff;
   logic [CARE_BITS-1:0]     care_mask_ff;
   logic [LEN_BITS-1:0]      pattern_len_ff;

   // scan state
   logic [OFFSET_BITS-1:0] count_ff, count_in;
   logic                   done_ff, done_in;

   // result register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_found_ff, rsp_found_in;
   logic [RESULT_BITS-1:0] rsp_offset_ff, rsp_offset_in;

   logic                               accept;
   logic [LEN_BITS-1:0]                len;
   logic [PATTERN_SLOTS-1:0][BYTE_BITS-1:0] pattern;
   logic [OFFSET_BITS-1:0]             count_next;
   logic [OFFSET_BITS-1:0]             offset;
   logic [63:0]                        offset_wide;
   logic                               any_miss;
   logic                               hit;
   logic                               emit;

   logic [MAX_PATTERN_BYTES-1:0][BYTE_BITS-1:0] cell_byte;
   logic [MAX_PATTERN_BYTES-1:0]                cell_miss;

   assign csr_ready  = 1'b1;
   assign accept     = req_tvalid & req_tready;
   assign req_tready = ~rsp_valid_ff | rsp_tready;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_low_ff  <= '0;
         pattern_high_ff <= '0;
         care_mask_ff    <= '0;
         pattern_len_ff  <= LEN_BITS'(1);
      end else if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_PATTERN_LOW:  pattern_low_ff  <= csr_data;
            CSR_PATTERN_HIGH: pattern_high_ff <= csr_data;
            CSR_CARE_MASK:    care_mask_ff    <= csr_data[CARE_BITS-1:0];
            CSR_PATTERN_LEN:  pattern_len_ff  <= csr_data[LEN_BITS-1:0];
            default: ;
         endcase
      end
   end

   // effective length, clamped to the cell capacity and the pattern slots
   assign len     = (pattern_len_ff > CAP_LEN) ? CAP_LEN : pattern_len_ff;
   assign pattern = {pattern_high_ff, pattern_low_ff};

   // cell chain: cell i holds the byte i places back from the newest
   for (genvar i = 0; i < MAX_PATTERN_BYTES; i++) begin : g_cell
      localparam logic [6:0] CELL_IDX = 7'(i);
      logic [BYTE_BITS-1:0] link;
      logic [3:0]           slot;
      cell_ctrl_type        ctrl;

      if (i == 0) begin : g_head
         assign link = req_tdata;
      end else begin : g_body
         assign link = cell_byte[i-1];
      end

      // pattern byte len-1-i lines up with this cell
      assign slot           = 4'(len - LEN_BITS'(i) - LEN_BITS'(1));
      assign ctrl.active    = {2'b00, len} > CELL_IDX;
      assign ctrl.care      = care_mask_ff[slot];
      assign ctrl.want_byte = pattern[slot];

      mbps_cell u_cell (
         .clock    (clock),
         .shift_en (accept),
         .byte_in  (link),
         .ctrl     (ctrl),
         .byte_out (cell_byte[i]),
         .miss     (cell_miss[i])
      );
   end

   assign any_miss = |cell_miss;

   // saturating byte count including the incoming word
   assign count_next = (count_ff == COUNT_MAX) ? count_ff : count_ff + OFFSET_BITS'(1);

   // match decision and start offset
   always_comb begin
      if (len == '0) begin
         hit    = ~done_ff;
         offset = count_next - OFFSET_BITS'(1);
      end else begin
         hit    = ~done_ff & (count_next >= OFFSET_BITS'(len)) & ~any_miss;
         offset = count_next - OFFSET_BITS'(len);
      end
   end

   assign offset_wide = 64'(offset);
   assign emit        = accept & (hit | (req_tlast & ~done_ff));

   // next scan state and result
   always_comb begin
      count_in      = count_ff;
      done_in       = done_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_offset_in = rsp_offset_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_tready;
      if (accept) begin
         count_in = count_next;
         done_in  = done_ff | hit;
         if (req_tlast) begin
            count_in = '0;
            done_in  = 1'b0;
         end
      end
      if (emit) begin
         rsp_valid_in  = 1'b1;
         rsp_found_in  = hit;
         rsp_offset_in = hit ? offset_wide[RESULT_BITS-1:0] : '0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         done_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         done_ff      <= done_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      rsp_found_ff  <= rsp_found_in;
      rsp_offset_ff <= rsp_offset_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_offset_ff;
   assign rsp_tuser  = rsp_found_ff;

endmodule

`default_nettype wire
